### src/sha1_pkg.sv
// sha1 message digest: shared types, constants and round helpers
// depends on nothing; imported by every module of the block
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned NumChain = 5;
  localparam int unsigned WinDepth = 16;

  localparam word_t H_INIT [NumChain] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam word_t K_0 = 32'h5A82_7999;
  localparam word_t K_1 = 32'h6ED9_EBA1;
  localparam word_t K_2 = 32'h8F1B_BCDC;
  localparam word_t K_3 = 32'hCA62_C1D6;

  localparam logic       CMD_ABSORB = 1'b0;
  localparam logic       CMD_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;

  // sequencer controls into the datapath
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       start;
    logic       round;
    logic [6:0] rnd;
    logic       add;
    logic       init;
  } ctrl_t;

  function automatic word_t k_of(input logic [6:0] rnd);
    word_t k;
    if (rnd inside {[7'd0:7'd19]}) begin
      k = K_0;
    end else if (rnd inside {[7'd20:7'd39]}) begin
      k = K_1;
    end else if (rnd inside {[7'd40:7'd59]}) begin
      k = K_2;
    end else begin
      k = K_3;
    end
    return k;
  endfunction

  function automatic word_t f_of(input logic [6:0] rnd, input word_t b, input word_t c,
                                 input word_t d);
    word_t f;
    if (rnd inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
    end else if (rnd inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

### src/sha1_if.sv
// sha1 message digest: valid/ready channel interfaces for items and digests
// depends on nothing
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, output digest_word4,
                  input ready);
  modport sink   (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input digest_word4,
                  output ready);
endinterface

`default_nettype wire

### src/sha1_msg_win.sv
// sha1 message window: 16-word shift line that gathers block bytes and
// then expands the message schedule one word per round; uses sha1_pkg
`default_nettype none

module sha1_msg_win import sha1_pkg::*; (
  input  wire logic  clk_i,
  input  wire ctrl_t ctrl_i,
  output word_t      w_o
);

  word_t win_q [WinDepth];
  word_t w_new;

  assign w_new = {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
                  win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_byte) begin
      // whole block moves up one byte, new byte enters at the bottom
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[WinDepth-1] <= {win_q[WinDepth-1][23:0], ctrl_i.byte_val};
    end else if (ctrl_i.round) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinDepth-1] <= w_new;
    end
  end

  assign w_o = win_q[0];

endmodule

`default_nettype wire

### src/sha1_round_unit.sv
// sha1 round unit: working words a..e, one round per cycle, and the chaining
// words with their feed-forward add; uses sha1_pkg
`default_nettype none

module sha1_round_unit import sha1_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctrl_t ctrl_i,
  input  wire word_t w_i,
  output word_t      h_o [NumChain]
);

  word_t h_q [NumChain];
  word_t a_q, b_q, c_q, d_q, e_q;
  word_t t_sum;

  assign t_sum = {a_q[26:0], a_q[31:27]} + f_of(ctrl_i.rnd, b_q, c_q, d_q) + e_q
               + k_of(ctrl_i.rnd) + w_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (ctrl_i.round) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= H_INIT;
    end else if (ctrl_i.init) begin
      h_q <= H_INIT;
    end else if (ctrl_i.add) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

  assign h_o = h_q;

endmodule

`default_nettype wire

### src/sha1_message_digest_top.sv
// sha1 message digest top: byte absorb, padding and round sequencer, digest register
// absorb: each item shifts in one byte; an item that completes a block then runs the rounds and the add
// finish: accept, pad out the block, rounds and add, then padding, rounds and add again when the length
// spills into a further block, then load the digest register; one item in flight at a time
// the single shared round unit sets the pace of every 64-byte block
// reset: chaining words to the sha1 initial values, counters cleared, no digest pending
`default_nettype none

module sha1_message_digest_top import sha1_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sha1_in_if.sink     req_i,
  sha1_out_if.source  rsp_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [6:0]  rnd_q, rnd_d;
  logic        first_q, first_d;
  logic        fin_q, fin_d;
  logic        last_q, last_d;
  logic        out_valid_q;
  logic        out_load;
  word_t       dig_q [NumChain];
  word_t       h    [NumChain];
  word_t       w;
  ctrl_t       ctrl;

  sha1_msg_win u_win (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_o    (w)
  );

  sha1_round_unit u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .w_i    (w),
    .h_o    (h)
  );

  always_comb begin
    ctrl     = '0;
    ctrl.rnd = rnd_q;
    state_d  = state_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    rnd_d    = rnd_q;
    first_d  = first_q;
    fin_d    = fin_q;
    last_d   = last_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.command == CMD_ABSORB) begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = req_i.data_byte;
            fill_d          = fill_q + 6'd1;
            cnt_d           = cnt_q + 61'd1;
            if (fill_q == FILL_LAST) begin
              ctrl.start = 1'b1;
              rnd_d      = '0;
              state_d    = ST_ROUND;
            end
          end else begin
            len_d   = {cnt_q, 3'b000};
            first_d = 1'b1;
            fin_d   = 1'b1;
            // length fits behind the pad byte only below position 56
            last_d  = (fill_q < LEN_POS);
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.shift_byte = 1'b1;
        if (first_q) begin
          ctrl.byte_val = PAD_BYTE;
        end else if (last_q && (fill_q >= LEN_POS)) begin
          ctrl.byte_val = len_q[63:56];
          len_d         = {len_q[55:0], 8'h00};
        end else begin
          ctrl.byte_val = 8'h00;
        end
        first_d = 1'b0;
        fill_d  = fill_q + 6'd1;
        if (fill_q == FILL_LAST) begin
          ctrl.start = 1'b1;
          rnd_d      = '0;
          state_d    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctrl.round = 1'b1;
        rnd_d      = rnd_q + 7'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        ctrl.add = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (last_q) begin
          state_d = ST_DONE;
        end else begin
          last_d  = 1'b1;
          state_d = ST_PAD;
        end
      end
      ST_DONE: begin
        // wait for the previous digest to leave before overwriting it
        if (!out_valid_q || rsp_o.ready) begin
          out_load  = 1'b1;
          ctrl.init = 1'b1;
          cnt_d     = '0;
          fin_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      first_q     <= 1'b0;
      fin_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      first_q <= first_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (out_load) begin
      dig_q <= h;
    end
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.digest_word0 = dig_q[0];
  assign rsp_o.digest_word1 = dig_q[1];
  assign rsp_o.digest_word2 = dig_q[2];
  assign rsp_o.digest_word3 = dig_q[3];
  assign rsp_o.digest_word4 = dig_q[4];

endmodule

`default_nettype wire

### src/sha1_chk.sv
// sha1 message digest: port-level checker and its bind to the top level
// depends on sha1_pkg and the top level's channel ports
`default_nettype none

module sha1_chk import sha1_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_command_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_word0_i,
  input wire logic [31:0] out_word4_i
);

  // a waiting digest stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("digest withdrawn while stalled");

  // a waiting digest holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word0_i) && $stable(out_word4_i))
    else $error("digest changed while stalled");

  // a finish item occupies the block for its padding and rounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_FINISH) |=> !in_ready_i)
    else $error("block ready right after finish");

  // an absorbed byte never raises a digest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_ABSORB) && !out_valid_i
    |=> !out_valid_i)
    else $error("digest after absorb item");

endmodule

bind sha1_message_digest_top sha1_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_command_i (req_i.command),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_word0_i  (rsp_o.digest_word0),
  .out_word4_i  (rsp_o.digest_word4)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// testbench for sha1_message_digest_top: byte and finish items in, digests out
// a built-in sha1 predictor checks every digest; needs sha1_pkg, sha1_if and the top

module testbench;
  import sha1_pkg::*;

  typedef logic [4:0][31:0] digest_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       wait_idle;  // hold this item back until every digest is in
  } msg_item_t;

  localparam digest_t SHA1_IV = {32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE,
                                 32'hEFCD_AB89, 32'h6745_2301};
  localparam word_t RK_0 = 32'h5A82_7999;
  localparam word_t RK_1 = 32'h6ED9_EBA1;
  localparam word_t RK_2 = 32'h8F1B_BCDC;
  localparam word_t RK_3 = 32'hCA62_C1D6;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned TAIL_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha1_in_if  req_if ();
  sha1_out_if rsp_if ();

  sha1_message_digest_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  digest_t     chain_h;
  logic [7:0]  blk_buf [64];
  logic [5:0]  blk_fill;
  logic [60:0] msg_len;

  msg_item_t   msg_items [$];
  digest_t     want_digests [$];

  int unsigned items_queued = 0;
  int unsigned msgs_queued = 0;
  int unsigned finishes_sent = 0;
  int unsigned digests_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned rsp_gap = 0;
  int unsigned rsp_calm = 0;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic hash_reset();
    chain_h  = SHA1_IV;
    blk_fill = '0;
    msg_len  = '0;
  endtask

  task automatic sha1_compress();
    word_t w [80];
    word_t a, b, c, d, e, f, k, t;
    int    i;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    end
    for (i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RK_0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RK_1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK_2;
      end else begin
        f = b ^ c ^ d;
        k = RK_3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endtask

  // one accepted item: absorb a byte, or pad, close the message and expect its digest
  task automatic hash_item(input msg_item_t it);
    logic [63:0] bit_len;
    int          pos;
    int          i;
    if (it.command == CMD_ABSORB) begin
      blk_buf[blk_fill] = it.data_byte;
      msg_len  = msg_len + 1'b1;
      blk_fill = blk_fill + 1'b1;
      if (blk_fill == 6'd0) begin
        sha1_compress();
      end
    end else begin
      bit_len = {msg_len, 3'b000};
      pos = blk_fill;
      blk_buf[pos] = 8'h80;
      pos++;
      // no room left for the length: pad out this block and start another
      if (pos > 56) begin
        while (pos < 64) begin
          blk_buf[pos] = 8'h00;
          pos++;
        end
        sha1_compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      for (i = 0; i < 8; i++) begin
        blk_buf[56+i] = bit_len[63-8*i -: 8];
      end
      sha1_compress();
      want_digests.push_back(chain_h);
      hash_reset();
    end
  endtask

  task automatic push_absorb(input logic [7:0] val, input logic hold);
    msg_items.push_back('{command: CMD_ABSORB, data_byte: val, wait_idle: hold});
    items_queued++;
  endtask

  task automatic push_finish(input logic hold);
    msg_items.push_back('{command: CMD_FINISH, data_byte: 8'($urandom_range(0, 255)),
                          wait_idle: hold});
    items_queued++;
    msgs_queued++;
  endtask

  task automatic queue_random_msg(input int unsigned len, input logic hold);
    int unsigned n;
    for (n = 0; n < len; n++) begin
      push_absorb(8'($urandom_range(0, 255)), hold && (n == 0));
    end
    push_finish(hold && (len == 0));
  endtask

  // driver
  always @(posedge clk_i) begin
    logic      nxt_valid;
    msg_item_t it;
    if (rst_ni) begin
      nxt_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        it = msg_items.pop_front();
        hash_item(it);
        if (it.command == CMD_FINISH) begin
          finishes_sent <= finishes_sent + 1;
        end
        nxt_valid = 1'b0;
        if (send_calm != 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 63) == 0) begin
            send_calm = $urandom_range(20, 80);
          end
        end
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (msg_items.size() != 0) begin
          if (!(msg_items[0].wait_idle && want_digests.size() != 0)) begin
            req_if.command   <= msg_items[0].command;
            req_if.data_byte <= msg_items[0].data_byte;
            nxt_valid = 1'b1;
          end
        end
      end
      req_if.valid <= nxt_valid;
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    digest_t got;
    digest_t want;
    int      i;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got[0] = rsp_if.digest_word0;
        got[1] = rsp_if.digest_word1;
        got[2] = rsp_if.digest_word2;
        got[3] = rsp_if.digest_word3;
        got[4] = rsp_if.digest_word4;
        digests_seen <= digests_seen + 1;
        if (want_digests.size() == 0) begin
          note_failure($sformatf("unexpected digest %h %h %h %h %h",
                                 got[0], got[1], got[2], got[3], got[4]));
        end else begin
          want = want_digests.pop_front();
          for (i = 0; i < 5; i++) begin
            if (got[i] !== want[i]) begin
              note_failure($sformatf("digest %0d word%0d: expected %h, got %h",
                                     digests_seen, i, want[i], got[i]));
            end
          end
        end
      end
      if (rsp_gap != 0) begin
        rsp_gap--;
      end else if (rsp_calm != 0) begin
        rsp_calm--;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_gap = pick_gap();
        if ($urandom_range(0, 31) == 0) begin
          rsp_calm = $urandom_range(30, 120);
        end
      end
      rsp_if.ready <= (rsp_gap == 0) && (hold_left == 0);
    end
  end

  // one long receiver hold-off so the digest register fills and the input stalls
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && digests_seen == 3) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL sha1_message_digest_top");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int unsigned r;
    req_if.valid     = 1'b0;
    req_if.command   = CMD_ABSORB;
    req_if.data_byte = 8'h00;
    rsp_if.ready     = 1'b0;
    hash_reset();

    // empty message, "abc", single all-zero and all-ones bytes
    push_finish(1'b0);
    push_absorb(8'h61, 1'b0);
    push_absorb(8'h62, 1'b0);
    push_absorb(8'h63, 1'b0);
    push_finish(1'b0);
    push_absorb(8'h00, 1'b0);
    push_finish(1'b0);
    push_absorb(8'hFF, 1'b0);
    push_finish(1'b0);

    // block and padding boundaries: length just fits, spills over, full block
    queue_random_msg(55, 1'b0);
    queue_random_msg(56, 1'b0);
    queue_random_msg(63, 1'b0);
    queue_random_msg(64, 1'b0);
    queue_random_msg(65, 1'b0);

    // the length wrap needs 2^61 bytes and is out of reach here
    while (items_queued < 650 || msgs_queued < 36) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = $urandom_range(0, 20);
      end else if (r < 9) begin
        case ($urandom_range(0, 5))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 119;
          4: len = 120;
          default: len = 128;
        endcase
      end else begin
        len = $urandom_range(21, 140);
      end
      queue_random_msg(len, msgs_queued == 16);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (msg_items.size() != 0 || want_digests.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (want_digests.size() != 0) begin
      note_failure($sformatf("%0d digests never arrived", want_digests.size()));
    end
    if (fail_count == 0) begin
      $display("PASS sha1_message_digest_top");
    end else begin
      $display("FAIL sha1_message_digest_top");
    end
    $finish;
  end

endmodule
